// ===== sv/sdpid_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register codes and beat types for the straight drive PID.
// No dependencies; every other file of the block imports this package.
package sdpid_pkg;

	// Encoder count bits that are used and width of the saturating error sum
	localparam int COUNT_WIDTH = 32;
	localparam int SUM_WIDTH   = 48;

	// Fixed field widths
	localparam int GAIN_W   = 32;
	localparam int SPEED_W  = 16;
	localparam int TARGET_W = 31;
	localparam int ERR_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Derived datapath widths
	localparam int CNT_EXT_W  = ERR_W + 1;
	localparam int DER_W      = ERR_W + 1;
	localparam int SUM_LO_W   = SUM_WIDTH / 2;
	localparam int SUM_HI_W   = SUM_WIDTH - SUM_LO_W;
	localparam int PROD_P_W   = GAIN_W + ERR_W;
	localparam int PROD_D_W   = GAIN_W + DER_W;
	localparam int PROD_IL_W  = GAIN_W + SUM_LO_W + 1;
	localparam int PROD_IH_W  = GAIN_W + SUM_HI_W;
	localparam int ACC_W      = GAIN_W + SUM_WIDTH + 3;
	localparam int CORR_SHIFT = 10;
	localparam int CORR_W     = SPEED_W + 2;
	localparam int SPD_SUM_W  = CORR_W + 1;

	// Register reset values
	localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 32'sd25166;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 32'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 32'sd16777;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 3'd0,
		REG_GAIN_I = 3'd1,
		REG_GAIN_D = 3'd2,
		REG_BASE   = 3'd3,
		REG_TARGET = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0]  gain_p;
		logic signed [GAIN_W-1:0]  gain_i;
		logic signed [GAIN_W-1:0]  gain_d;
		logic signed [SPEED_W-1:0] base_speed;
		logic [TARGET_W-1:0]       target_pulses;
	} cfg_t;

	// Input and result beats
	typedef struct packed {
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} item_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic                      done_res;
	} res_t;

	// Per-stage load strobes from the pipeline control
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
		logic load_s4;
		logic load_o;
	} pipe_ctl_t;

	// Stage payloads
	typedef struct packed {
		logic                        done;
		logic signed [ERR_W-1:0]     err;
		logic signed [SUM_WIDTH-1:0] sum;
		logic signed [DER_W-1:0]     der;
	} s2_t;

	typedef struct packed {
		logic                        done;
		logic signed [PROD_P_W-1:0]  prod_p;
		logic signed [PROD_D_W-1:0]  prod_d;
		logic signed [PROD_IL_W-1:0] prod_il;
		logic signed [PROD_IH_W-1:0] prod_ih;
	} s3_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] acc;
	} s4_t;

endpackage

// ===== sv/sdpid_front.sv =====
`timescale 1ns / 1ps
// Input register, target check, error / sum / derivative and the PID state.
// Depends on sdpid_pkg.
module sdpid_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdpid_pkg::pipe_ctl_t ctl,
	input  sdpid_pkg::cfg_t      cfg,
	input  sdpid_pkg::item_t     item,
	output sdpid_pkg::s2_t       front_s2
);
	import sdpid_pkg::*;

	item_t item_s1;

	logic signed [ERR_W-1:0]     last_error_q;
	logic signed [SUM_WIDTH-1:0] error_sum_q;

	logic signed [CNT_EXT_W-1:0] left_x, right_x, pair_sum, pair_rnd, avg, diff;
	logic signed [ERR_W-1:0]     err;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [DER_W-1:0]     der;
	logic                        done;

	// Input register
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			item_s1 <= item;
		end
	end

	// Target check and error terms
	always_comb begin
		left_x  = {{(CNT_EXT_W-COUNT_WIDTH){item_s1.left_count[COUNT_WIDTH-1]}},
			item_s1.left_count[COUNT_WIDTH-1:0]};
		right_x = {{(CNT_EXT_W-COUNT_WIDTH){item_s1.right_count[COUNT_WIDTH-1]}},
			item_s1.right_count[COUNT_WIDTH-1:0]};

		// average rounded toward zero: add one to a negative sum before halving
		pair_sum = left_x + right_x;
		pair_rnd = pair_sum + CNT_EXT_W'(pair_sum[CNT_EXT_W-1]);
		avg      = {pair_rnd[CNT_EXT_W-1], pair_rnd[CNT_EXT_W-1:1]};
		done     = avg >= $signed({2'b00, cfg.target_pulses});

		// error saturated to 32 bits
		diff = left_x - right_x;
		if (diff[CNT_EXT_W-1] != diff[ERR_W-1]) begin
			err = diff[CNT_EXT_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
		end else begin
			err = diff[ERR_W-1:0];
		end

		// saturating error sum
		sum_wide = {error_sum_q[SUM_WIDTH-1], error_sum_q}
			+ {{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
				: {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end

		der = {err[ERR_W-1], err} - {last_error_q[ERR_W-1], last_error_q};
	end

	// PID state moves only on a driving beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (ctl.load_s2 && !done) begin
			last_error_q <= err;
			error_sum_q  <= sum_next;
		end
	end

	// Stage two register
	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			front_s2.done <= done;
			front_s2.err  <= err;
			front_s2.sum  <= sum_next;
			front_s2.der  <= der;
		end
	end

endmodule

// ===== sv/sdpid_mult.sv =====
`timescale 1ns / 1ps
// Gain multipliers: P and D terms, I term split in two partial products.
// Depends on sdpid_pkg.
module sdpid_mult (
	input  logic                 clk,
	input  sdpid_pkg::pipe_ctl_t ctl,
	input  sdpid_pkg::cfg_t      cfg,
	input  sdpid_pkg::s2_t       front_s2,
	output sdpid_pkg::s3_t       mult_s3
);
	import sdpid_pkg::*;

	logic signed [PROD_P_W-1:0]  prod_p;
	logic signed [PROD_D_W-1:0]  prod_d;
	logic signed [PROD_IL_W-1:0] prod_il;
	logic signed [PROD_IH_W-1:0] prod_ih;

	// sum = hi * 2^SUM_LO_W + lo, with lo taken as unsigned
	always_comb begin
		prod_p  = PROD_P_W'(cfg.gain_p) * PROD_P_W'(front_s2.err);
		prod_d  = PROD_D_W'(cfg.gain_d) * PROD_D_W'(front_s2.der);
		prod_il = PROD_IL_W'(cfg.gain_i)
			* PROD_IL_W'($signed({1'b0, front_s2.sum[SUM_LO_W-1:0]}));
		prod_ih = PROD_IH_W'(cfg.gain_i)
			* PROD_IH_W'($signed(front_s2.sum[SUM_WIDTH-1:SUM_LO_W]));
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s3) begin
			mult_s3.done    <= front_s2.done;
			mult_s3.prod_p  <= prod_p;
			mult_s3.prod_d  <= prod_d;
			mult_s3.prod_il <= prod_il;
			mult_s3.prod_ih <= prod_ih;
		end
	end

endmodule

// ===== sv/sdpid_out.sv =====
`timescale 1ns / 1ps
// Correction accumulate, Q2.14 scaling and saturated wheel speeds.
// Depends on sdpid_pkg.
module sdpid_out (
	input  logic                 clk,
	input  sdpid_pkg::pipe_ctl_t ctl,
	input  sdpid_pkg::cfg_t      cfg,
	input  sdpid_pkg::s3_t       mult_s3,
	output sdpid_pkg::res_t      res_q
);
	import sdpid_pkg::*;

	s4_t acc_s4;

	logic signed [ACC_W-1:0]     term_p, term_d, term_il, term_ih, acc;
	logic signed [ACC_W-1:0]     corr_full;
	logic [ACC_W-CORR_W:0]       corr_top;
	logic signed [CORR_W-1:0]    corr;
	logic signed [SPD_SUM_W-1:0] base_x, left_w, right_w;
	res_t                        res_next;

	function automatic logic signed [SPEED_W-1:0] sat_speed(
		input logic signed [SPD_SUM_W-1:0] v
	);
		logic [SPD_SUM_W-SPEED_W:0] top;
		top = v[SPD_SUM_W-1:SPEED_W-1];
		if (&top || ~|top) begin
			return v[SPEED_W-1:0];
		end
		return v[SPD_SUM_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
	endfunction

	// Sum of the three gain terms
	always_comb begin
		term_p  = ACC_W'(mult_s3.prod_p);
		term_d  = ACC_W'(mult_s3.prod_d);
		term_il = ACC_W'(mult_s3.prod_il);
		term_ih = ACC_W'(mult_s3.prod_ih);
		acc     = term_p + term_d + term_il + (term_ih <<< SUM_LO_W);
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			acc_s4.done <= mult_s3.done;
			acc_s4.acc  <= acc;
		end
	end

	// Floor shift to Q2.14, clamp, then speeds
	always_comb begin
		corr_full = acc_s4.acc >>> CORR_SHIFT;
		corr_top  = corr_full[ACC_W-1:CORR_W-1];
		// any correction this far out saturates both speeds anyway
		if (&corr_top || ~|corr_top) begin
			corr = corr_full[CORR_W-1:0];
		end else begin
			corr = corr_full[ACC_W-1] ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
		end
		base_x  = {{(SPD_SUM_W-SPEED_W){cfg.base_speed[SPEED_W-1]}}, cfg.base_speed};
		left_w  = base_x - {corr[CORR_W-1], corr};
		right_w = base_x + {corr[CORR_W-1], corr};

		if (acc_s4.done) begin
			res_next.left_speed  = '0;
			res_next.right_speed = '0;
			res_next.done_res    = 1'b1;
		end else begin
			res_next.left_speed  = sat_speed(left_w);
			res_next.right_speed = sat_speed(right_w);
			res_next.done_res    = 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.load_o) begin
			res_q <= res_next;
		end
	end

endmodule

// ===== sv/straight_drive_pid_unit.sv =====
`timescale 1ns / 1ps
// Straight drive PID: one result beat for every encoder beat, throughput one
// beat per clock while results are taken. Each beat passes through the input
// register, error and state update, gain multiplies, accumulate, then the
// result register. The only loop is the error sum and last error update, which
// closes in that stage and lets a beat follow in every cycle. Every stage
// holds under back pressure and empty stages still take beats, so input
// ready drops only when all five stages hold beats and the result is not
// taken. Configuration writes are
// always taken (cfg_ready is high); unknown indexes are dropped. Write them
// only with the pipeline empty. A beat whose count average has reached the
// target gives zero speeds with done_res set and leaves the PID state alone.
// Depends on sdpid_pkg, sdpid_front, sdpid_mult and sdpid_out.
module straight_drive_pid_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sdpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdpid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  sdpid_pkg::item_t               item,
	output logic                           res_valid,
	input  logic                           res_ready,
	output sdpid_pkg::res_t                res
);
	import sdpid_pkg::*;

	cfg_t      cfg_q;
	pipe_ctl_t ctl;
	s2_t       front_s2;
	s3_t       mult_s3;

	logic valid_s1_q, valid_s2_q, valid_s3_q, valid_s4_q, valid_o_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_o;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p        <= GAIN_P_RST;
			cfg_q.gain_i        <= GAIN_I_RST;
			cfg_q.gain_d        <= GAIN_D_RST;
			cfg_q.base_speed    <= '0;
			cfg_q.target_pulses <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_P: cfg_q.gain_p        <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I: cfg_q.gain_i        <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D: cfg_q.gain_d        <= cfg_data[GAIN_W-1:0];
				REG_BASE:   cfg_q.base_speed    <= cfg_data[SPEED_W-1:0];
				REG_TARGET: cfg_q.target_pulses <= cfg_data[TARGET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Ready chain: a stage takes a beat when empty or when it drains
	assign rdy_o  = !valid_o_q  || res_ready;
	assign rdy_s4 = !valid_s4_q || rdy_o;
	assign rdy_s3 = !valid_s3_q || rdy_s4;
	assign rdy_s2 = !valid_s2_q || rdy_s3;
	assign rdy_s1 = !valid_s1_q || rdy_s2;

	assign item_ready = rdy_s1;
	assign res_valid  = valid_o_q;

	assign ctl.load_s1 = item_valid && rdy_s1;
	assign ctl.load_s2 = valid_s1_q && rdy_s2;
	assign ctl.load_s3 = valid_s2_q && rdy_s3;
	assign ctl.load_s4 = valid_s3_q && rdy_s4;
	assign ctl.load_o  = valid_s4_q && rdy_o;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
			valid_s3_q <= 1'b0;
			valid_s4_q <= 1'b0;
			valid_o_q  <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1_q <= item_valid;
			if (rdy_s2) valid_s2_q <= valid_s1_q;
			if (rdy_s3) valid_s3_q <= valid_s2_q;
			if (rdy_s4) valid_s4_q <= valid_s3_q;
			if (rdy_o)  valid_o_q  <= valid_s4_q;
		end
	end

	sdpid_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg      (cfg_q),
		.item     (item),
		.front_s2 (front_s2)
	);

	sdpid_mult u_mult (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg_q),
		.front_s2 (front_s2),
		.mult_s3  (mult_s3)
	);

	sdpid_out u_out (
		.clk     (clk),
		.ctl     (ctl),
		.cfg     (cfg_q),
		.mult_s3 (mult_s3),
		.res_q   (res)
	);

endmodule

// ===== test/tb_straight_drive_pid_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for straight_drive_pid_unit: a directed table, random config phases and
// a run of saturated errors, each result checked against a PID predictor kept in the bench.
// Depends on sdpid_pkg and the straight_drive_pid_unit RTL.
module tb_straight_drive_pid_unit;
	import sdpid_pkg::*;

	localparam logic signed [31:0] CNT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] CNT_MIN = 32'sh8000_0000;
	localparam longint SUM_MAX = (longint'(1) << (SUM_WIDTH - 1)) - 1;
	localparam longint SUM_MIN = -(longint'(1) << (SUM_WIDTH - 1));
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 64;
	localparam int PHASES = 5;
	localparam int PHASE_BEATS = 190;
	localparam int SAT_TAIL = 40;
	localparam res_t STOP_BEAT = res_t'{16'sd0, 16'sd0, 1'b1};
	localparam res_t FLOOR_BEAT = res_t'{16'sh8000, 16'sh8000, 1'b0};
	localparam res_t CEIL_BEAT = res_t'{16'sh7fff, 16'sh7fff, 1'b0};

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_t;
	typedef enum int {GAINS_TUNED, GAINS_RAW, GAINS_RAIL, GAINS_PD} gain_style_t;

	// One line of the directed table: either a register write or an encoder beat
	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		item_t                 beat;
		bit                    fixed;
		res_t                  cmd;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  item_valid;
	logic                  item_ready;
	item_t                 item;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res;

	// Predictor copy of the registers and the PID state
	logic signed [GAIN_W-1:0]  pid_gain_p = GAIN_P_RST;
	logic signed [GAIN_W-1:0]  pid_gain_i = GAIN_I_RST;
	logic signed [GAIN_W-1:0]  pid_gain_d = GAIN_D_RST;
	logic signed [SPEED_W-1:0] pid_base = '0;
	logic [TARGET_W-1:0]       pid_target = '0;
	longint                    pid_last_err = 0;
	longint                    pid_err_sum = 0;

	res_t motor_cmd_q[$];
	row_t dir_tab[$];
	logic tag_fixed;
	res_t tag_cmd;
	res_t pred_cmd;
	res_t want_cmd;
	int   errors = 0;
	int   checked = 0;
	int   stops = 0;
	int   beats_in = 0;
	int   cfg_writes = 0;
	int   sat_beats = 0;
	int   burst_left = 0;
	int   hold_ask = 0;

	straight_drive_pid_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [127:0] mul_w(logic signed [127:0] a, logic signed [127:0] b);
		return a * b;
	endfunction

	function automatic logic signed [SPEED_W-1:0] sat_speed(logic signed [127:0] v);
		if (v > 128'sd32767) return 16'sh7fff;
		if (v < -128'sd32768) return 16'sh8000;
		return v[SPEED_W-1:0];
	endfunction

	function automatic logic signed [31:0] clip_count(longint v);
		if (v > CNT_MAX) return CNT_MAX;
		if (v < CNT_MIN) return CNT_MIN;
		return v[31:0];
	endfunction

	// Motor commands for one control tick; updates the PID state unless the target is reached
	function automatic res_t pid_tick(item_t beat);
		longint l, r, avg, err, der;
		logic signed [127:0] acc, corr;
		res_t o;
		l = beat.left_count;
		r = beat.right_count;
		avg = (l + r) / 2;
		if (avg >= longint'(pid_target)) return STOP_BEAT;
		err = l - r;
		if (err > CNT_MAX) err = CNT_MAX;
		else if (err < CNT_MIN) err = CNT_MIN;
		pid_err_sum = pid_err_sum + err;
		if (pid_err_sum > SUM_MAX) pid_err_sum = SUM_MAX;
		else if (pid_err_sum < SUM_MIN) pid_err_sum = SUM_MIN;
		der = err - pid_last_err;
		pid_last_err = err;
		acc = mul_w(pid_gain_p, err) + mul_w(pid_gain_i, pid_err_sum) + mul_w(pid_gain_d, der);
		corr = acc >>> CORR_SHIFT;
		o.left_speed = sat_speed(pid_base - corr);
		o.right_speed = sat_speed(pid_base + corr);
		o.done_res = 1'b0;
		return o;
	endfunction

	function automatic void pid_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_GAIN_P: pid_gain_p = data;
			REG_GAIN_I: pid_gain_i = data;
			REG_GAIN_D: pid_gain_d = data;
			REG_BASE:   pid_base = data[SPEED_W-1:0];
			REG_TARGET: pid_target = data[TARGET_W-1:0];
			default: ;
		endcase
	endfunction

	// Directed table helpers
	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		row_t row;
		row = '{is_cfg: 1'b1, idx: idx, data: data, beat: '0, fixed: 1'b0, cmd: '0};
		dir_tab.push_back(row);
	endfunction

	function automatic void add_typed(logic signed [31:0] l, logic signed [31:0] r, res_t cmd);
		row_t row;
		row = '{is_cfg: 1'b0, idx: '0, data: '0, beat: item_t'{l, r}, fixed: 1'b1, cmd: cmd};
		dir_tab.push_back(row);
	endfunction

	function automatic void add_beat(logic signed [31:0] l, logic signed [31:0] r);
		row_t row;
		row = '{is_cfg: 1'b0, idx: '0, data: '0, beat: item_t'{l, r}, fixed: 1'b0, cmd: '0};
		dir_tab.push_back(row);
	endfunction

	function automatic void build_table();
		// reset settings: target 0, so any non-negative average stops
		add_typed(32'sd0, 32'sd0, STOP_BEAT);
		add_typed(CNT_MAX, CNT_MAX, STOP_BEAT);
		add_typed(CNT_MAX, CNT_MIN, STOP_BEAT);     // sum -1, average truncates to 0
		add_typed(-32'sd1, 32'sd0, STOP_BEAT);
		add_beat(-32'sd1, -32'sd2);
		add_beat(CNT_MIN, CNT_MIN);
		add_typed(CNT_MIN, CNT_MAX, STOP_BEAT);
		// top bit of the target write is dropped
		add_cfg(REG_TARGET, 32'hffff_ffff);
		add_typed(CNT_MAX, CNT_MAX, STOP_BEAT);
		add_beat(CNT_MAX, CNT_MIN);                 // error saturates high
		add_beat(CNT_MIN, CNT_MAX);                 // error saturates low
		add_beat(CNT_MAX, CNT_MAX - 32'sd1);        // one below the target
		// gains on the rails: correction far beyond its 18-bit clamp
		add_cfg(REG_GAIN_P, 32'h7fff_ffff);
		add_cfg(REG_GAIN_I, 32'h8000_0000);
		add_cfg(REG_GAIN_D, 32'h7fff_ffff);
		add_beat(CNT_MAX, CNT_MIN);
		add_beat(CNT_MIN, CNT_MAX);
		add_beat(32'sd0, 32'sd0);
		// no correction: speeds are the base as written, outside the nominal range too
		add_cfg(REG_GAIN_P, '0);
		add_cfg(REG_GAIN_I, '0);
		add_cfg(REG_GAIN_D, '0);
		add_cfg(REG_BASE, 32'hffff_8000);
		add_typed(32'sd0, 32'sd0, FLOOR_BEAT);
		add_cfg(REG_BASE, 32'h0000_7fff);
		add_typed(32'sd5, -32'sd3, CEIL_BEAT);
		// writes to unused indexes must change nothing
		add_cfg(IDX_SPARE_LO, 32'hffff_ffff);
		add_cfg(IDX_SPARE_HI, 32'h0000_0000);
		add_typed(32'sd1, 32'sd2, CEIL_BEAT);
		add_cfg(REG_GAIN_I, 32'd1);
		add_cfg(REG_GAIN_P, 32'h8000_0000);
		add_cfg(REG_BASE, 32'd16384);
		add_beat(32'sd100, -32'sd100);
		add_beat(-32'sd5, 32'sd7);
		add_cfg(REG_TARGET, '0);
		add_cfg(REG_BASE, 32'h0000_c000);
		add_beat(-32'sd10, 32'sd3);
		add_typed(32'sd3, -32'sd3, STOP_BEAT);
	endfunction

	function automatic logic signed [31:0] corner_count();
		case ($urandom_range(0, 5))
			0: return CNT_MIN;
			1: return CNT_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			default: return CNT_MIN + 32'sd1;
		endcase
	endfunction

	// Encoder beat mix: mostly counts near the target, plus raw, wide and corner values
	function automatic item_t random_beat();
		item_t b;
		longint anchor;
		int pick;
		pick = $urandom_range(0, 99);
		anchor = longint'(pid_target) + longint'($urandom_range(0, 4000)) - 2000;
		if (pick < 40) begin
			b.left_count = clip_count(anchor + longint'($urandom_range(0, 600)) - 300);
			b.right_count = clip_count(anchor + longint'($urandom_range(0, 600)) - 300);
		end else if (pick < 60) begin
			b.left_count = $urandom;
			b.right_count = $urandom;
		end else if (pick < 80) begin
			b.left_count = clip_count(anchor + longint'($urandom_range(0, 131072)) - 65536);
			b.right_count = clip_count(anchor + longint'($urandom_range(0, 131072)) - 65536);
		end else if (pick < 90) begin
			b.left_count = corner_count();
			b.right_count = corner_count();
		end else begin
			// average on the target or one step either side
			b.left_count = clip_count(anchor);
			b.right_count = clip_count(2 * longint'(pid_target) - anchor
				+ longint'($urandom_range(0, 4)) - 2);
		end
		return b;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] gain_pick(gain_style_t style, int bits);
		case (style)
			GAINS_TUNED: return $urandom_range(0, 2 << bits) - (1 << bits);
			GAINS_RAW:   return $urandom;
			GAINS_RAIL: begin
				case ($urandom_range(0, 2))
					0: return CNT_MAX;
					1: return CNT_MIN;
					default: return '0;
				endcase
			end
			default: return (bits > 8) ? $urandom_range(0, 1 << bits) : '0;
		endcase
	endfunction

	task automatic send_beat(item_t beat, bit fixed, res_t cmd);
		item <= beat;
		item_valid <= 1'b1;
		tag_fixed <= fixed;
		tag_cmd <= cmd;
		do @(posedge clk); while (!item_ready);
	endtask

	// Sender bursts: random length, random gaps, sometimes long stretches with no gap
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
	endtask

	// Stop sending and wait until every expected command has come back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (motor_cmd_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		pid_write(idx, data);
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_setup();
		gain_style_t style;
		style = gain_style_t'($urandom_range(0, 3));
		write_reg(REG_GAIN_P, gain_pick(style, 20));
		write_reg(REG_GAIN_I, gain_pick(style, 8));
		write_reg(REG_GAIN_D, gain_pick(style, 20));
		write_reg(REG_BASE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32768) - 16384);
		case ($urandom_range(0, 9))
			0: write_reg(REG_TARGET, '0);
			1: write_reg(REG_TARGET, CNT_MAX);
			2, 3, 4: write_reg(REG_TARGET, $urandom);
			default: write_reg(REG_TARGET, $urandom_range(0, 5000));
		endcase
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), $urandom);
	endtask

	// Each accepted encoder beat steps the predictor; typed rows supply their own answer
	always @(posedge clk) begin
		if (item_valid && item_ready) begin
			pred_cmd = pid_tick(item);
			motor_cmd_q.push_back(tag_fixed ? tag_cmd : pred_cmd);
			beats_in++;
		end
	end

	// Result check against the oldest expected command
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (motor_cmd_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, got %p", $time, res);
			end else begin
				want_cmd = motor_cmd_q.pop_front();
				checked++;
				if (want_cmd.done_res) stops++;
				if (res.left_speed !== want_cmd.left_speed) begin
					errors++;
					$display("%0t: left_speed expected %0d got %0d", $time,
						want_cmd.left_speed, res.left_speed);
				end
				if (res.right_speed !== want_cmd.right_speed) begin
					errors++;
					$display("%0t: right_speed expected %0d got %0d", $time,
						want_cmd.right_speed, res.right_speed);
				end
				if (res.done_res !== want_cmd.done_res) begin
					errors++;
					$display("%0t: done_res expected %0b got %0b", $time,
						want_cmd.done_res, res.done_res);
				end
			end
		end
	end

	// Receiver: stall pattern changes every so often; a request from the stimulus
	// forces one long hold-off
	initial begin : rx_pattern
		rx_mode_t mode;
		int mode_left;
		int hold_seen;
		res_ready <= 1'b0;
		mode = RX_OPEN;
		mode_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_ask) begin
				hold_seen = hold_ask;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   res_ready <= 1'b1;
					RX_COIN:   res_ready <= $urandom_range(0, 1);
					RX_SPARSE: res_ready <= ($urandom_range(0, 7) != 0);
					default:   res_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		item_t b;
		int n;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		tag_fixed <= 1'b0;
		tag_cmd <= '0;
		build_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				drain();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_beat(dir_tab[i].beat, dir_tab[i].fixed, dir_tab[i].cmd);
				pace();
			end
		end

		// random phases, each under fresh settings
		for (int p = 0; p < PHASES; p++) begin
			drain();
			random_setup();
			if (p == 2) begin
				// receiver holds off while beats keep coming, so the input must stall
				hold_ask++;
				repeat (30) send_beat(random_beat(), 1'b0, '0);
			end
			for (n = 0; n < PHASE_BEATS; n++) begin
				if (p == 3 && n == PHASE_BEATS / 2) drain();
				send_beat(random_beat(), 1'b0, '0);
				pace();
			end
		end

		// Saturated positive error on every beat, back to back: the sum grows at its
		// fastest and the large P term pins both speeds.
		drain();
		write_reg(REG_GAIN_P, 32'hffff_0000);
		write_reg(REG_GAIN_I, 32'd1);
		write_reg(REG_GAIN_D, '0);
		write_reg(REG_BASE, '0);
		write_reg(REG_TARGET, CNT_MAX);
		for (n = 0; n < SAT_TAIL; n++) begin
			b.left_count = $urandom_range(0, CNT_MAX);
			b.right_count = CNT_MIN + $urandom_range(0, b.left_count);
			send_beat(b, 1'b0, '0);
			sat_beats++;
		end
		for (n = 0; n < 20; n++) begin
			send_beat(random_beat(), 1'b0, '0);
			pace();
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Checked %0d result beats (%0d at target) from %0d encoder beats,", checked,
			stops, beats_in);
		$display("%0d register writes; %0d beats of saturated error in a row.",
			cfg_writes, sat_beats);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
